[rtl/core/hsfd_pkg.sv]
package hsfd_pkg;

    // CRC-8 over each two-byte word: poly x^8+x^5+x^4+1, MSB first, no reflection
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_TOPBIT = 8'h80;

    // byte positions within a frame
    typedef logic [2:0] pos_t;
    localparam pos_t POS_TEMP_HI = 3'd0;
    localparam pos_t POS_TEMP_LO = 3'd1;
    localparam pos_t POS_TEMP_CK = 3'd2;
    localparam pos_t POS_HUM_HI  = 3'd3;
    localparam pos_t POS_HUM_LO  = 3'd4;
    localparam pos_t POS_HUM_CK  = 3'd5;

    // scale factors; products stay below 2^31
    localparam int PROD_W  = 31;
    localparam int QUOT_W  = 15;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [QUOT_W-1:0] quot_t;
    localparam prod_t TEMP_SCALE   = 31'd17500;
    localparam prod_t HUM_SCALE    = 31'd10000;
    localparam quot_t TEMP_OFFSET  = 15'd4500;
    localparam logic [16:0] DIVISOR = 17'd65535;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOPBIT) != 8'h00)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

[rtl/core/hsfd_scale.sv]
// floor(prod / 65535) for products whose quotient fits in 15 bits.
// q0 = prod >> 16 never overshoots; remainder prod - q0*65535 = lo + q0 stays
// below twice the divisor, so a single compare fixes it up.
module hsfd_scale
(
    input  hsfd_pkg::prod_t prod,
    output hsfd_pkg::quot_t quot
);

    hsfd_pkg::quot_t q0;
    logic [16:0]     rem0;

    assign q0   = prod[30:16];
    assign rem0 = {1'b0, prod[15:0]} + {2'b00, q0};
    assign quot = (rem0 >= hsfd_pkg::DIVISOR) ? q0 + 15'd1 : q0;

endmodule

[rtl/core/humidity_sensor_frame_decoder_core.sv]
// Temperature/humidity frame decoder. Bytes of a six-byte frame arrive one per
// transfer: temperature word (high byte first), its CRC-8, humidity word (high
// byte first), its CRC-8. The CRC uses polynomial 0x31 seeded with 0xFF over
// each word. frame_start on a byte makes it byte zero and drops any partial
// frame; without it the position simply counts 0..5 and wraps. On the sixth
// byte one result transfer follows carrying both check flags (the result is
// sent even when checks fail), the raw words, temperature in 0.01 C
// (floor(17500*raw/65535) - 4500) and humidity in 0.01 %RH
// (floor(10000*raw/65535)). Throughput is one byte per cycle while the input
// is not stalled; a frame's last byte goes into the stage-one register and
// then into the output register that drives result_valid. Stage one takes
// the check flags and held words and registers the scale products; stage two
// divides by 65535 with a shift-add estimate and one correction into the
// output register. The input stalls only when both stages hold results that
// the output side has not taken.
module humidity_sensor_frame_decoder_core
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               frame_valid,
    output logic               frame_ready,
    input  logic [7:0]         frame_byte,
    input  logic               frame_start,

    output logic               result_valid,
    input  logic               result_ready,
    output logic               frame_ok,
    output logic               temp_check_ok,
    output logic               hum_check_ok,
    output logic [15:0]        raw_temp_word,
    output logic [15:0]        raw_hum_word,
    output logic signed [14:0] temp_centidegrees,
    output logic [13:0]        hum_centipercent
);

    // ---- byte tracking state ----
    hsfd_pkg::pos_t pos_reg, pos_next, pos_cur;
    logic [7:0]     crc_reg, crc_next;
    logic [15:0]    temp_hold_reg, temp_hold_next;
    logic [15:0]    hum_hold_reg, hum_hold_next;
    logic           temp_ok_reg, temp_ok_next;
    logic           hum_ok_cur;

    // ---- stage one: products waiting for the divide ----
    logic           s1_valid_reg;
    logic           s1_temp_ok_reg, s1_hum_ok_reg;
    logic [15:0]    s1_temp_word_reg, s1_hum_word_reg;
    hsfd_pkg::prod_t s1_temp_prod_reg, s1_hum_prod_reg;

    // ---- output register ----
    logic           out_valid_reg;
    logic           out_temp_ok_reg, out_hum_ok_reg;
    logic [15:0]    out_temp_word_reg, out_hum_word_reg;
    logic [14:0]    out_temp_reg;
    logic [13:0]    out_hum_reg;

    logic           accept;
    logic           out_adv;
    logic           last_byte;
    hsfd_pkg::quot_t temp_quot, hum_quot;

    assign out_adv     = !out_valid_reg || result_ready;
    assign frame_ready = !s1_valid_reg || out_adv;
    assign accept      = frame_valid && frame_ready;

    // position of this byte: start flag forces zero, unreachable codes fold to zero
    always_comb
    begin
        pos_cur = frame_start ? hsfd_pkg::POS_TEMP_HI : pos_reg;
        if (pos_cur > hsfd_pkg::POS_HUM_CK)
            pos_cur = hsfd_pkg::POS_TEMP_HI;
    end

    assign last_byte  = (pos_cur == hsfd_pkg::POS_HUM_CK);
    assign hum_ok_cur = (crc_reg == frame_byte);

    always_comb
    begin
        crc_next       = crc_reg;
        temp_hold_next = temp_hold_reg;
        hum_hold_next  = hum_hold_reg;
        temp_ok_next   = temp_ok_reg;
        pos_next       = pos_cur + 3'd1;
        case (pos_cur)
            hsfd_pkg::POS_TEMP_HI:
            begin
                crc_next       = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, frame_byte);
                temp_hold_next = {frame_byte, 8'h00};
            end
            hsfd_pkg::POS_TEMP_LO:
            begin
                crc_next       = hsfd_pkg::crc8_byte(crc_reg, frame_byte);
                temp_hold_next = {temp_hold_reg[15:8], frame_byte};
            end
            hsfd_pkg::POS_TEMP_CK:
            begin
                temp_ok_next = (crc_reg == frame_byte);
                crc_next     = hsfd_pkg::CRC_INIT;
            end
            hsfd_pkg::POS_HUM_HI:
            begin
                crc_next      = hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, frame_byte);
                hum_hold_next = {frame_byte, 8'h00};
            end
            hsfd_pkg::POS_HUM_LO:
            begin
                crc_next      = hsfd_pkg::crc8_byte(crc_reg, frame_byte);
                hum_hold_next = {hum_hold_reg[15:8], frame_byte};
            end
            hsfd_pkg::POS_HUM_CK:
            begin
                crc_next = hsfd_pkg::CRC_INIT;
                pos_next = hsfd_pkg::POS_TEMP_HI;
            end
            default:
            begin
                crc_next = crc_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= hsfd_pkg::POS_TEMP_HI;
            crc_reg       <= hsfd_pkg::CRC_INIT;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
            end
            if (frame_ready)
                s1_valid_reg <= accept && last_byte;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // word holds and pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_hold_reg <= temp_hold_next;
            hum_hold_reg  <= hum_hold_next;
            temp_ok_reg   <= temp_ok_next;
        end
        if (accept && last_byte)
        begin
            s1_temp_ok_reg   <= temp_ok_reg;
            s1_hum_ok_reg    <= hum_ok_cur;
            s1_temp_word_reg <= temp_hold_reg;
            s1_hum_word_reg  <= hum_hold_reg;
            s1_temp_prod_reg <= {15'd0, temp_hold_reg} * hsfd_pkg::TEMP_SCALE;
            s1_hum_prod_reg  <= {15'd0, hum_hold_reg} * hsfd_pkg::HUM_SCALE;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_temp_ok_reg   <= s1_temp_ok_reg;
            out_hum_ok_reg    <= s1_hum_ok_reg;
            out_temp_word_reg <= s1_temp_word_reg;
            out_hum_word_reg  <= s1_hum_word_reg;
            out_temp_reg      <= temp_quot - hsfd_pkg::TEMP_OFFSET;
            out_hum_reg       <= hum_quot[13:0];
        end
    end

    // divide by 65535
    hsfd_scale u_temp_scale
    (
        .prod (s1_temp_prod_reg),
        .quot (temp_quot)
    );

    hsfd_scale u_hum_scale
    (
        .prod (s1_hum_prod_reg),
        .quot (hum_quot)
    );

    assign result_valid      = out_valid_reg;
    assign frame_ok          = out_temp_ok_reg && out_hum_ok_reg;
    assign temp_check_ok     = out_temp_ok_reg;
    assign hum_check_ok      = out_hum_ok_reg;
    assign raw_temp_word     = out_temp_word_reg;
    assign raw_hum_word      = out_hum_word_reg;
    assign temp_centidegrees = $signed(out_temp_reg);
    assign hum_centipercent  = out_hum_reg;

endmodule

[rtl/core/hsfd_checker.sv]
module hsfd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input logic               frame_ok,
    input logic               temp_check_ok,
    input logic               hum_check_ok,
    input logic [15:0]        raw_temp_word,
    input logic [15:0]        raw_hum_word,
    input logic signed [14:0] temp_centidegrees,
    input logic [13:0]        hum_centipercent
);

    // stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(raw_temp_word)
            && $stable(raw_hum_word) && $stable(temp_centidegrees))
        else $error("result changed while stalled");

    // overall flag is the AND of the two word checks
    a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> frame_ok == (temp_check_ok && hum_check_ok))
        else $error("frame_ok inconsistent with word checks");

    // scaled values stay within sensor range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> temp_centidegrees >= -15'sd4500
            && temp_centidegrees <= 15'sd13000 && hum_centipercent <= 14'd10000)
        else $error("scaled value out of range");

    // full-scale humidity and zero temperature raw words land on the end points
    a_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (raw_hum_word != 16'hFFFF || hum_centipercent == 14'd10000)
            && (raw_temp_word != 16'h0000 || temp_centidegrees == -15'sd4500))
        else $error("scaling end point wrong");

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .frame_ok          (frame_ok),
    .temp_check_ok     (temp_check_ok),
    .hum_check_ok      (hum_check_ok),
    .raw_temp_word     (raw_temp_word),
    .raw_hum_word      (raw_hum_word),
    .temp_centidegrees (temp_centidegrees),
    .hum_centipercent  (hum_centipercent)
);
